// ===== rtl/xcrc_pkg.sv =====
`default_nettype none

package xcrc_pkg;

    localparam int PAYLOAD_BYTES   = 128;
    localparam int EXT_BLOCK_BYTES = 65536;
    localparam int COUNT_BITS      = 12;

    localparam int WORDS         = PAYLOAD_BYTES / 8;
    localparam int WORD_IDX_BITS = $clog2(WORDS);
    localparam int OFF_BITS      = $clog2(PAYLOAD_BYTES);
    localparam int PAY_SHIFT     = $clog2(PAYLOAD_BYTES);
    localparam int TOTAL_BITS    = 19;

    // frame positions: header is three bytes, crc follows the payload
    localparam logic [7:0] PAYLOAD_POS = 8'd3;
    localparam logic [7:0] CRC_HI_POS  = 8'(PAYLOAD_BYTES + 3);
    localparam logic [7:0] CRC_LO_POS  = 8'(PAYLOAD_BYTES + 4);
    localparam logic [7:0] LEN_MAX     = 8'hFF;

    localparam logic [15:0] CRC_POLY  = 16'h1021;
    localparam logic [15:0] CRC_INIT  = 16'h0000;
    localparam logic [15:0] TIMER_MAX = 16'hFFFF;
    localparam logic [15:0] POLL_PERIOD_RESET = 16'd1000;

    localparam logic [7:0] CH_SOH  = 8'h01;
    localparam logic [7:0] CH_EOT  = 8'h04;
    localparam logic [7:0] CH_ACK  = 8'h06;
    localparam logic [7:0] CH_NAK  = 8'h15;
    localparam logic [7:0] CH_POLL = 8'h43;

    localparam logic [1:0] REQ_BYTE  = 2'd0;
    localparam logic [1:0] REQ_TICK  = 2'd1;
    localparam logic [1:0] REQ_START = 2'd2;

    localparam logic [1:0] KIND_REPLY = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;

    localparam logic [1:0] REG_TARGET_EXT  = 2'd0;
    localparam logic [1:0] REG_BLOCK_NUM   = 2'd1;
    localparam logic [1:0] REG_INT_BASE    = 2'd2;
    localparam logic [1:0] REG_POLL_PERIOD = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_CRC,
        ST_FINISH,
        ST_READ,
        ST_WRITE,
        ST_REPLY,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/xmodem_crc_receiver.sv =====
// a request is decoded in the cycle after acceptance; a payload byte then goes bit by bit
// through the bit-serial crc shifter; ready returns only once the request is finished
// a good packet end adds 16 word writes, each through a read state (payload memory
// read port) and a write state, plus the ack, all held while the output is stalled;
// output results leave via a register
// reset: rst_n is asynchronous active low, clears control state, config takes its defaults
`default_nettype none

module xmodem_crc_receiver (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // config write channel
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [31:0]  cfg_data,
    // input requests
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,   // rx_byte
    input  wire logic [1:0]   s_axis_tuser,   // req_type
    input  wire logic         s_axis_tlast,   // frame_end
    // results
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // reply_byte[7:0], write_addr[39:8], write_data[103:40], total_bytes[122:104], zeros
    output logic [127:0]      m_axis_tdata,
    output logic [1:0]        m_axis_tuser,   // out_kind
    output logic              m_axis_tlast    // last
);

    localparam int DATA_BITS = 8 + 32 + 64 + xcrc_pkg::TOTAL_BITS;

    xcrc_pkg::state_t state_reg, state_next;

    logic [1:0]  req_reg;
    logic [7:0]  byte_reg;
    logic        fend_reg;
    logic [7:0]  pos_reg;

    logic [7:0]  frame_len_reg, frame_len_next;
    logic [7:0]  first_byte_reg, first_byte_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] rcrc_reg, rcrc_next;
    logic [xcrc_pkg::COUNT_BITS-1:0] count_reg, count_next;
    logic [15:0] timer_reg, timer_next;
    logic        active_reg, active_next;
    logic        polling_reg, polling_next;

    logic        target_ext_reg;
    logic [3:0]  block_num_reg;
    logic [31:0] int_base_reg;
    logic [15:0] poll_period_reg;

    logic [2:0]  bit_cnt_reg, bit_cnt_next;
    logic [xcrc_pkg::WORD_IDX_BITS-1:0] word_cnt_reg, word_cnt_next;
    logic [31:0] addr_reg, addr_next;
    logic [7:0]  reply_code_reg, reply_code_next;
    logic        eot_reg, eot_next;

    logic        m_valid_reg, m_valid_next;
    logic [1:0]  m_kind_reg, m_kind_next;
    logic        m_last_reg, m_last_next;
    logic [DATA_BITS-1:0] m_data_reg, m_data_next;

    logic [63:0] mem [0:xcrc_pkg::WORDS-1];
    logic [63:0] rd_data_reg;
    logic        mem_we;
    logic [xcrc_pkg::OFF_BITS-1:0] mem_off;

    logic        in_accept;
    logic        out_free;
    logic        is_payload;
    logic        poll_fire;
    logic        pkt_end;
    logic        eot_end;
    logic        crc_ok;
    logic        last_word;
    logic [31:0] ext_base;
    logic [31:0] pkt_base;
    logic [15:0] crc_shift;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == xcrc_pkg::ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;

    assign is_payload = (pos_reg >= xcrc_pkg::PAYLOAD_POS) && (pos_reg < xcrc_pkg::CRC_HI_POS);
    assign poll_fire  = active_reg && polling_reg && (timer_reg >= poll_period_reg);
    assign pkt_end    = fend_reg && (pos_reg == xcrc_pkg::CRC_LO_POS)
                        && (first_byte_reg == xcrc_pkg::CH_SOH);
    assign eot_end    = fend_reg && (pos_reg == 8'd0) && (byte_reg == xcrc_pkg::CH_EOT);
    assign crc_ok     = (crc_reg == rcrc_reg);
    assign last_word  = (word_cnt_reg == xcrc_pkg::WORD_IDX_BITS'(xcrc_pkg::WORDS - 1));
    assign mem_off    = xcrc_pkg::OFF_BITS'(pos_reg - xcrc_pkg::PAYLOAD_POS);

    assign ext_base  = 32'(32'(block_num_reg) * xcrc_pkg::EXT_BLOCK_BYTES);
    assign pkt_base  = (target_ext_reg ? ext_base : int_base_reg)
                       + 32'({count_reg, {xcrc_pkg::PAY_SHIFT{1'b0}}});

    // the crc unit: one msb-first step of the crc polynomial division
    assign crc_shift = crc_reg[15] ? ({crc_reg[14:0], 1'b0} ^ xcrc_pkg::CRC_POLY)
                                   : {crc_reg[14:0], 1'b0};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            xcrc_pkg::ST_IDLE:
            begin
                if (in_accept)
                    state_next = xcrc_pkg::ST_DECODE;
            end
            xcrc_pkg::ST_DECODE:
            begin
                if (req_reg == xcrc_pkg::REQ_BYTE)
                begin
                    if (!active_reg)
                        state_next = xcrc_pkg::ST_IDLE;
                    else if (is_payload)
                        state_next = xcrc_pkg::ST_CRC;
                    else
                        state_next = xcrc_pkg::ST_FINISH;
                end
                else if (req_reg == xcrc_pkg::REQ_TICK && poll_fire)
                    state_next = xcrc_pkg::ST_REPLY;
                else
                    state_next = xcrc_pkg::ST_IDLE;
            end
            xcrc_pkg::ST_CRC:
            begin
                if (bit_cnt_reg == 3'd7)
                    state_next = xcrc_pkg::ST_FINISH;
            end
            xcrc_pkg::ST_FINISH:
            begin
                if (pkt_end)
                    state_next = crc_ok ? xcrc_pkg::ST_READ : xcrc_pkg::ST_REPLY;
                else if (eot_end)
                    state_next = xcrc_pkg::ST_REPLY;
                else
                    state_next = xcrc_pkg::ST_IDLE;
            end
            xcrc_pkg::ST_READ:
                state_next = xcrc_pkg::ST_WRITE;
            xcrc_pkg::ST_WRITE:
            begin
                if (out_free)
                    state_next = last_word ? xcrc_pkg::ST_REPLY : xcrc_pkg::ST_READ;
            end
            xcrc_pkg::ST_REPLY:
            begin
                if (out_free)
                    state_next = eot_reg ? xcrc_pkg::ST_DONE : xcrc_pkg::ST_IDLE;
            end
            xcrc_pkg::ST_DONE:
            begin
                if (out_free)
                    state_next = xcrc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        frame_len_next  = frame_len_reg;
        first_byte_next = first_byte_reg;
        crc_next        = crc_reg;
        rcrc_next       = rcrc_reg;
        count_next      = count_reg;
        timer_next      = timer_reg;
        active_next     = active_reg;
        polling_next    = polling_reg;
        bit_cnt_next    = bit_cnt_reg;
        word_cnt_next   = word_cnt_reg;
        addr_next       = addr_reg;
        reply_code_next = reply_code_reg;
        eot_next        = eot_reg;
        mem_we          = 1'b0;
        m_valid_next    = m_valid_reg && !m_axis_tready;
        m_kind_next     = m_kind_reg;
        m_last_next     = m_last_reg;
        m_data_next     = m_data_reg;

        unique case (state_reg)
            xcrc_pkg::ST_DECODE:
            begin
                if (req_reg == xcrc_pkg::REQ_START)
                begin
                    active_next     = 1'b1;
                    polling_next    = 1'b1;
                    timer_next      = 16'd0;
                    count_next      = '0;
                    frame_len_next  = 8'd0;
                    crc_next        = xcrc_pkg::CRC_INIT;
                    rcrc_next       = 16'd0;
                    first_byte_next = 8'd0;
                end
                else if (req_reg == xcrc_pkg::REQ_TICK)
                begin
                    if (active_reg && polling_reg)
                    begin
                        // a poll restarts the count, then the tick itself is counted
                        if (poll_fire)
                        begin
                            timer_next      = 16'd1;
                            reply_code_next = xcrc_pkg::CH_POLL;
                            eot_next        = 1'b0;
                        end
                        else if (timer_reg != xcrc_pkg::TIMER_MAX)
                            timer_next = timer_reg + 16'd1;
                    end
                end
                else if (req_reg == xcrc_pkg::REQ_BYTE)
                begin
                    if (!active_reg)
                    begin
                        frame_len_next = 8'd0;
                        crc_next       = xcrc_pkg::CRC_INIT;
                    end
                    else
                    begin
                        if (pos_reg == 8'd0)
                        begin
                            first_byte_next = byte_reg;
                            crc_next        = xcrc_pkg::CRC_INIT;
                        end
                        if (is_payload)
                        begin
                            crc_next     = crc_reg ^ {byte_reg, 8'h00};
                            bit_cnt_next = 3'd0;
                            mem_we       = 1'b1;
                        end
                        else if (pos_reg == xcrc_pkg::CRC_HI_POS)
                            rcrc_next = {byte_reg, rcrc_reg[7:0]};
                        else if (pos_reg == xcrc_pkg::CRC_LO_POS)
                            rcrc_next = {rcrc_reg[15:8], byte_reg};
                        if (frame_len_reg != xcrc_pkg::LEN_MAX)
                            frame_len_next = frame_len_reg + 8'd1;
                    end
                end
            end
            xcrc_pkg::ST_CRC:
            begin
                crc_next     = crc_shift;
                bit_cnt_next = bit_cnt_reg + 3'd1;
            end
            xcrc_pkg::ST_FINISH:
            begin
                if (fend_reg)
                begin
                    frame_len_next = 8'd0;
                    crc_next       = xcrc_pkg::CRC_INIT;
                end
                if (pkt_end)
                begin
                    polling_next = 1'b0;
                    eot_next     = 1'b0;
                    if (crc_ok)
                    begin
                        count_next    = count_reg + 1'b1;
                        addr_next     = pkt_base;
                        word_cnt_next = '0;
                    end
                    else
                        reply_code_next = xcrc_pkg::CH_NAK;
                end
                else if (eot_end)
                begin
                    reply_code_next = xcrc_pkg::CH_ACK;
                    eot_next        = 1'b1;
                    active_next     = 1'b0;
                    polling_next    = 1'b0;
                end
            end
            xcrc_pkg::ST_WRITE:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_kind_next   = xcrc_pkg::KIND_WRITE;
                    m_last_next   = 1'b0;
                    m_data_next   = {{xcrc_pkg::TOTAL_BITS{1'b0}}, rd_data_reg, addr_reg, 8'h00};
                    addr_next     = addr_reg + 32'd8;
                    word_cnt_next = word_cnt_reg + 1'b1;
                    if (last_word)
                        reply_code_next = xcrc_pkg::CH_ACK;
                end
            end
            xcrc_pkg::ST_REPLY:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_kind_next  = xcrc_pkg::KIND_REPLY;
                    m_last_next  = !eot_reg;
                    m_data_next  = {{(DATA_BITS-8){1'b0}}, reply_code_reg};
                end
            end
            xcrc_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_kind_next  = xcrc_pkg::KIND_DONE;
                    m_last_next  = 1'b1;
                    m_data_next  = {xcrc_pkg::TOTAL_BITS'({count_reg, {xcrc_pkg::PAY_SHIFT{1'b0}}}),
                                    {(DATA_BITS-xcrc_pkg::TOTAL_BITS){1'b0}}};
                end
            end
            xcrc_pkg::ST_IDLE,
            xcrc_pkg::ST_READ:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= xcrc_pkg::ST_IDLE;
            frame_len_reg   <= 8'd0;
            first_byte_reg  <= 8'd0;
            crc_reg         <= 16'd0;
            rcrc_reg        <= 16'd0;
            count_reg       <= '0;
            timer_reg       <= 16'd0;
            active_reg      <= 1'b0;
            polling_reg     <= 1'b0;
            bit_cnt_reg     <= 3'd0;
            word_cnt_reg    <= '0;
            eot_reg         <= 1'b0;
            m_valid_reg     <= 1'b0;
            target_ext_reg  <= 1'b0;
            block_num_reg   <= 4'd1;
            int_base_reg    <= 32'd0;
            poll_period_reg <= xcrc_pkg::POLL_PERIOD_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            frame_len_reg  <= frame_len_next;
            first_byte_reg <= first_byte_next;
            crc_reg        <= crc_next;
            rcrc_reg       <= rcrc_next;
            count_reg      <= count_next;
            timer_reg      <= timer_next;
            active_reg     <= active_next;
            polling_reg    <= polling_next;
            bit_cnt_reg    <= bit_cnt_next;
            word_cnt_reg   <= word_cnt_next;
            eot_reg        <= eot_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    xcrc_pkg::REG_TARGET_EXT:  target_ext_reg  <= cfg_data[0];
                    xcrc_pkg::REG_BLOCK_NUM:   block_num_reg   <= cfg_data[3:0];
                    xcrc_pkg::REG_INT_BASE:    int_base_reg    <= cfg_data;
                    xcrc_pkg::REG_POLL_PERIOD: poll_period_reg <= cfg_data[15:0];
                endcase
            end
        end
    end

    // request capture and datapath registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            req_reg  <= s_axis_tuser;
            byte_reg <= s_axis_tdata;
            fend_reg <= s_axis_tlast;
            pos_reg  <= frame_len_reg;
        end
        addr_reg       <= addr_next;
        reply_code_reg <= reply_code_next;
        m_kind_reg     <= m_kind_next;
        m_last_reg     <= m_last_next;
        m_data_reg     <= m_data_next;
    end

    // payload memory: byte writes, registered word read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_off[xcrc_pkg::OFF_BITS-1:3]][{mem_off[2:0], 3'b000} +: 8] <= byte_reg;
        rd_data_reg <= mem[word_cnt_reg];
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_kind_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tdata  = {{(128-DATA_BITS){1'b0}}, m_data_reg};

endmodule

`default_nettype wire

// ===== rtl/xcrc_checker.sv =====
`default_nettype none

module xcrc_checker (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         cfg_valid,
    input wire logic         cfg_ready,
    input wire logic [1:0]   cfg_index,
    input wire logic [31:0]  cfg_data,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic [7:0]   s_axis_tdata,
    input wire logic [1:0]   s_axis_tuser,
    input wire logic         s_axis_tlast,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [127:0] m_axis_tdata,
    input wire logic [1:0]   m_axis_tuser,
    input wire logic         m_axis_tlast
);

    // one request at a time: the sequencer is busy right after taking one
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready straight after a request");

    // word writes never close a request, done always does
    a_write_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == xcrc_pkg::KIND_WRITE |-> !m_axis_tlast)
        else $error("word write marked last");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == xcrc_pkg::KIND_DONE |-> m_axis_tlast)
        else $error("done result not marked last");

    a_reply_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == xcrc_pkg::KIND_REPLY |->
            (m_axis_tdata[7:0] == xcrc_pkg::CH_ACK || m_axis_tdata[7:0] == xcrc_pkg::CH_NAK
             || m_axis_tdata[7:0] == xcrc_pkg::CH_POLL) && m_axis_tdata[127:8] == '0)
        else $error("bad reply byte");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind xmodem_crc_receiver xcrc_checker u_xcrc_checker (.*);

`default_nettype wire

// ===== bench/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import xcrc_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES  = 24;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_REPORTS    = 40;
    localparam int PAD_LSB        = 104 + TOTAL_BITS;

    typedef enum {
        FLOW_STEADY,
        FLOW_SENDER_GAPS,
        FLOW_RECEIVER_STALLS,
        FLOW_BOTH_GAPS,
        FLOW_HOLDOFF
    } flow_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] octet;
        logic       frame_end;
    } link_req_t;

    typedef struct packed {
        logic [1:0]            kind;
        logic [7:0]            reply;
        logic [31:0]           addr;
        logic [63:0]           data;
        logic [TOTAL_BITS-1:0] total;
        logic                  is_last;
    } rx_outcome_t;

    logic         clk           = 1'b0;
    logic         rst_n         = 1'b0;
    logic         cfg_valid     = 1'b0;
    logic         cfg_ready;
    logic [1:0]   cfg_index     = '0;
    logic [31:0]  cfg_data      = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata  = '0;
    logic [1:0]   s_axis_tuser  = '0;
    logic         s_axis_tlast  = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         m_axis_tlast;

    // receiver state as the block should hold it
    logic                  cfg_target_ext  = 1'b0;
    logic [3:0]            cfg_block       = 4'd1;
    logic [31:0]           cfg_int_base    = '0;
    logic [15:0]           cfg_poll_period = POLL_PERIOD_RESET;
    logic [7:0]            frame_pos       = '0;
    logic [7:0]            lead_byte       = '0;
    logic [15:0]           crc_run         = '0;
    logic [15:0]           crc_rx          = '0;
    logic [63:0]           payload_words [WORDS] = '{default: '0};
    logic [COUNT_BITS-1:0] packets_rx      = '0;
    logic [15:0]           poll_ticks      = '0;
    logic                  session_open    = 1'b0;
    logic                  polling_c       = 1'b0;

    link_req_t   req_queue[$];
    rx_outcome_t rx_outcomes[$];

    flow_t flow            = FLOW_STEADY;
    int    requests_queued = 0;
    int    requests_taken  = 0;
    int    mismatch_count  = 0;
    int    results_seen    = 0;
    int    writes_seen     = 0;
    int    replies_seen    = 0;
    int    dones_seen      = 0;
    int    settings_used   = 1;
    int    holdoff_left    = 0;
    bit    holdoff_done    = 1'b0;
    int    quiet_cycles    = 0;

    xmodem_crc_receiver u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic bit roll(input int pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic logic [15:0] crc16_xmodem(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    function automatic void owe_result(input logic [1:0] kind, input logic [7:0] reply,
                                       input logic [31:0] addr, input logic [63:0] data,
                                       input logic [TOTAL_BITS-1:0] total);
        rx_outcome_t r;
        r.kind    = kind;
        r.reply   = reply;
        r.addr    = addr;
        r.data    = data;
        r.total   = total;
        r.is_last = 1'b0;
        rx_outcomes.push_back(r);
    endfunction

    function automatic void apply_reg(input logic [1:0] idx, input logic [31:0] val);
        case (idx)
            REG_TARGET_EXT:  cfg_target_ext  = val[0];
            REG_BLOCK_NUM:   cfg_block       = val[3:0];
            REG_INT_BASE:    cfg_int_base    = val;
            REG_POLL_PERIOD: cfg_poll_period = val[15:0];
            default: ;
        endcase
    endfunction

    // works out the replies, flash writes and completion caused by one request
    function automatic void xmodem_rx_apply(input logic [1:0] req, input logic [7:0] octet,
                                            input logic fend);
        logic [7:0]  pos;
        logic [31:0] base;
        logic [31:0] offset;
        logic [31:0] bytes_total;
        int          lane;
        int          mark;
        mark = rx_outcomes.size();
        pos  = frame_pos;
        if (req == REQ_START)
        begin
            session_open = 1'b1;
            polling_c    = 1'b1;
            poll_ticks   = '0;
            packets_rx   = '0;
            frame_pos    = '0;
            crc_run      = '0;
            crc_rx       = '0;
            lead_byte    = '0;
        end
        else if (req == REQ_TICK)
        begin
            if (session_open && polling_c)
            begin
                if (poll_ticks >= cfg_poll_period)
                begin
                    owe_result(KIND_REPLY, CH_POLL, '0, '0, '0);
                    poll_ticks = '0;
                end
                if (poll_ticks != TIMER_MAX)
                    poll_ticks = poll_ticks + 16'd1;
            end
        end
        else if (req == REQ_BYTE)
        begin
            if (!session_open)
            begin
                frame_pos = '0;
                crc_run   = '0;
            end
            else
            begin
                if (pos == 8'd0)
                begin
                    lead_byte = octet;
                    crc_run   = CRC_INIT;
                end
                if (pos >= PAYLOAD_POS && pos < CRC_HI_POS)
                begin
                    lane    = int'(pos - PAYLOAD_POS);
                    crc_run = crc16_xmodem(crc_run, octet);
                    payload_words[lane / 8][(lane % 8) * 8 +: 8] = octet;
                end
                else if (pos == CRC_HI_POS)
                    crc_rx[15:8] = octet;
                else if (pos == CRC_LO_POS)
                    crc_rx[7:0] = octet;
                if (frame_pos != LEN_MAX)
                    frame_pos = frame_pos + 8'd1;

                if (fend)
                begin
                    if (pos == CRC_LO_POS && lead_byte == CH_SOH)
                    begin
                        polling_c = 1'b0;
                        if (crc_run == crc_rx)
                        begin
                            offset     = 32'(packets_rx) * 32'(PAYLOAD_BYTES);
                            packets_rx = packets_rx + 1'b1;
                            base = cfg_target_ext ? 32'(cfg_block) * 32'(EXT_BLOCK_BYTES)
                                                  : cfg_int_base;
                            for (int w = 0; w < WORDS; w++)
                            begin
                                owe_result(KIND_WRITE, '0, base + offset + 32'(w * 8),
                                           payload_words[w], '0);
                            end
                            owe_result(KIND_REPLY, CH_ACK, '0, '0, '0);
                        end
                        else
                            owe_result(KIND_REPLY, CH_NAK, '0, '0, '0);
                    end
                    else if (pos == 8'd0 && octet == CH_EOT)
                    begin
                        bytes_total = 32'(packets_rx) * 32'(PAYLOAD_BYTES);
                        owe_result(KIND_REPLY, CH_ACK, '0, '0, '0);
                        owe_result(KIND_DONE, '0, '0, '0, bytes_total[TOTAL_BITS-1:0]);
                        session_open = 1'b0;
                        polling_c    = 1'b0;
                    end
                    frame_pos = '0;
                    crc_run   = '0;
                end
            end
        end
        if (rx_outcomes.size() > mark)
            rx_outcomes[rx_outcomes.size() - 1].is_last = 1'b1;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got)
        begin
            if (mismatch_count < MAX_REPORTS)
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    // request driver
    always @(posedge clk)
    begin : feed_requests
        link_req_t pending;
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                xmodem_rx_apply(s_axis_tuser, s_axis_tdata, s_axis_tlast);
                requests_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (req_queue.size() != 0 &&
                    !roll(flow == FLOW_SENDER_GAPS ? 86 : flow == FLOW_BOTH_GAPS ? 11 : 0))
                begin
                    pending = req_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= pending.kind;
                    s_axis_tdata  <= pending.octet;
                    s_axis_tlast  <= pending.frame_end;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin : watch_results
        rx_outcome_t want;
        bit          stall;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                case (m_axis_tuser)
                    KIND_WRITE: writes_seen++;
                    KIND_REPLY: replies_seen++;
                    KIND_DONE:  dones_seen++;
                    default: ;
                endcase
                if (rx_outcomes.size() == 0)
                begin
                    if (mismatch_count < MAX_REPORTS)
                        $error("unexpected result: out_kind %0d, tdata 0x%0h",
                               m_axis_tuser, m_axis_tdata);
                    mismatch_count++;
                end
                else
                begin
                    want = rx_outcomes.pop_front();
                    check_field("out_kind", 64'(want.kind), 64'(m_axis_tuser));
                    check_field("reply_byte", 64'(want.reply), 64'(m_axis_tdata[7:0]));
                    check_field("write_addr", 64'(want.addr), 64'(m_axis_tdata[39:8]));
                    check_field("write_data", want.data, m_axis_tdata[103:40]);
                    check_field("total_bytes", 64'(want.total),
                                64'(m_axis_tdata[PAD_LSB-1:104]));
                    check_field("tdata_pad", 64'd0, 64'(m_axis_tdata[127:PAD_LSB]));
                    check_field("last", 64'(want.is_last), 64'(m_axis_tlast));
                end
            end

            // one long hold-off so that the block backs up into its input
            if (holdoff_left != 0)
            begin
                holdoff_left--;
                stall = 1'b1;
            end
            else if (flow == FLOW_HOLDOFF && !holdoff_done && m_axis_tvalid)
            begin
                holdoff_left = HOLDOFF_CYCLES;
                holdoff_done = 1'b1;
                stall = 1'b1;
            end
            else
                stall = roll(flow == FLOW_RECEIVER_STALLS ? 86 : flow == FLOW_BOTH_GAPS ? 11 : 0);
            m_axis_tready <= !stall;
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("testbench: no progress for %0d cycles, %0d results still owed",
                     WATCHDOG_LIMIT, rx_outcomes.size());
            $display("testbench: done, errors");
            $finish;
        end
    end

    function automatic void queue_req(input logic [1:0] kind, input logic [7:0] octet,
                                      input logic fend);
        link_req_t r;
        r.kind      = kind;
        r.octet     = octet;
        r.frame_end = fend;
        req_queue.push_back(r);
        requests_queued++;
    endfunction

    function automatic void queue_ticks(input int n);
        for (int i = 0; i < n; i++)
        begin
            queue_req(REQ_TICK, 8'($urandom), 1'($urandom));
        end
    endfunction

    function automatic void queue_eot();
        queue_req(REQ_BYTE, CH_EOT, 1'b1);
    endfunction

    // soh, sequence, complement, payload, crc; ticks may fall inside the frame
    function automatic void queue_packet(input logic [7:0] seq, input bit corrupt,
                                         input int tick_pct);
        logic [15:0] crc;
        logic [7:0]  b;
        crc = CRC_INIT;
        queue_req(REQ_BYTE, CH_SOH, 1'b0);
        queue_req(REQ_BYTE, seq, 1'b0);
        queue_req(REQ_BYTE, ~seq, 1'b0);
        for (int i = 0; i < PAYLOAD_BYTES; i++)
        begin
            b   = 8'($urandom);
            crc = crc16_xmodem(crc, b);
            queue_req(REQ_BYTE, b, 1'b0);
            if (roll(tick_pct))
                queue_req(REQ_TICK, 8'($urandom), 1'($urandom));
        end
        if (corrupt)
            crc = crc ^ 16'(1 << $urandom_range(15));
        queue_req(REQ_BYTE, crc[15:8], 1'b0);
        queue_req(REQ_BYTE, crc[7:0], 1'b1);
    endfunction

    function automatic void queue_raw_frame(input logic [7:0] lead, input int len);
        queue_req(REQ_BYTE, lead, len == 1);
        for (int i = 1; i < len; i++)
        begin
            queue_req(REQ_BYTE, 8'($urandom), i == len - 1);
        end
    endfunction

    // start of a packet that never gets its frame end
    function automatic void queue_partial(input int len);
        queue_req(REQ_BYTE, CH_SOH, 1'b0);
        for (int i = 1; i < len; i++)
        begin
            queue_req(REQ_BYTE, 8'($urandom), 1'b0);
        end
    endfunction

    // one transfer: mostly good packets, with bad crcs, stray frames, ticks and restarts
    function automatic void queue_session(input int frames);
        logic [7:0] seq;
        int         pick;
        seq = 8'd1;
        queue_req(REQ_START, 8'($urandom), 1'($urandom));
        queue_ticks($urandom_range(0, 6));
        for (int i = 0; i < frames; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 60)
            begin
                queue_packet(seq, 1'b0, 3);
                seq++;
            end
            else if (pick < 70)
                queue_packet(seq, 1'b1, 3);
            else if (pick < 76)
                queue_raw_frame($urandom_range(1) ? CH_SOH : 8'($urandom),
                                $urandom_range(1, 140));
            else if (pick < 80)
                queue_raw_frame(CH_SOH, $urandom_range(256, 300));
            else if (pick < 86)
                queue_ticks($urandom_range(1, 8));
            else if (pick < 90)
                queue_req(REQ_UNUSED, 8'($urandom), 1'($urandom));
            else if (pick < 95)
            begin
                queue_partial($urandom_range(1, 130));
                queue_req(REQ_START, 8'($urandom), 1'($urandom));
            end
            else
            begin
                // early end, then bytes nobody listens to, then a new transfer
                queue_eot();
                queue_raw_frame(8'($urandom), $urandom_range(1, 5));
                queue_req(REQ_START, 8'($urandom), 1'($urandom));
            end
        end
        if ($urandom_range(9) != 0)
            queue_eot();
    endfunction

    task automatic set_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic ext, input logic [3:0] blk, input logic [31:0] base,
                             input logic [15:0] period);
        set_reg(REG_TARGET_EXT, 32'(ext));
        set_reg(REG_BLOCK_NUM, 32'(blk));
        set_reg(REG_INT_BASE, base);
        set_reg(REG_POLL_PERIOD, 32'(period));
        settings_used++;
    endtask

    // sender holds back until everything owed has come out and the block is quiet
    task automatic drain();
        while (requests_taken != requests_queued)
            @(posedge clk);
        while (rx_outcomes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : stimulus
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: inactive traffic, empty transfer, stray frames, good and bad packets
        flow = FLOW_STEADY;
        queue_req(REQ_BYTE, CH_EOT, 1'b1);
        queue_req(REQ_BYTE, 8'hFF, 1'b0);
        queue_req(REQ_TICK, 8'h00, 1'b0);
        queue_req(REQ_UNUSED, 8'hAA, 1'b1);
        queue_req(REQ_START, 8'h55, 1'b0);
        queue_ticks(2);
        queue_eot();
        queue_req(REQ_START, 8'hFF, 1'b1);
        queue_raw_frame(CH_SOH, 1);
        queue_req(REQ_BYTE, CH_EOT, 1'b0);
        queue_req(REQ_BYTE, CH_EOT, 1'b1);
        queue_packet(8'd1, 1'b0, 0);
        queue_packet(8'd2, 1'b1, 0);
        queue_packet(8'd2, 1'b0, 0);
        queue_raw_frame(8'h02, 133);
        queue_eot();
        drain();

        // zero period polls on every tick; block zero; restart mid-frame; overlong frame
        configure(1'b1, 4'd0, 32'h0, 16'd0);
        queue_req(REQ_START, 8'h00, 1'b0);
        queue_ticks(3);
        queue_packet(8'd1, 1'b0, 0);
        queue_ticks(2);
        queue_partial(50);
        queue_req(REQ_START, 8'h00, 1'b0);
        queue_ticks(2);
        queue_packet(8'd1, 1'b0, 0);
        queue_raw_frame(CH_SOH, 260);
        queue_eot();
        drain();

        configure(1'b1, 4'd15, $urandom, 16'd1);
        flow = FLOW_SENDER_GAPS;
        queue_session(6);
        drain();

        // top of the address space, so word addresses wrap
        configure(1'b0, 4'd9, 32'hFFFF_FFFF, 16'd2);
        flow = FLOW_RECEIVER_STALLS;
        queue_session(6);
        drain();

        configure(1'b0, 4'd1, 32'h0, 16'd1);
        flow = FLOW_BOTH_GAPS;
        queue_session(6);
        drain();

        configure(1'b1, 4'd9, $urandom, 16'd3);
        flow = FLOW_HOLDOFF;
        queue_req(REQ_START, 8'h00, 1'b0);
        queue_packet(8'd1, 1'b0, 0);
        queue_packet(8'd2, 1'b0, 0);
        queue_session(5);
        drain();

        // longest poll period, run right through to its first poll
        configure(1'b0, 4'd1, $urandom, 16'hFFFF);
        flow = FLOW_STEADY;
        queue_req(REQ_START, 8'h00, 1'b0);
        queue_ticks(65540);
        queue_packet(8'd1, 1'b0, 0);
        queue_eot();
        drain();

        configure(1'($urandom), 4'($urandom), $urandom, 16'($urandom_range(1, 8)));
        flow = FLOW_BOTH_GAPS;
        queue_session(6);
        drain();

        $display("testbench: %0d requests under %0d register settings, %0d results checked",
                 requests_taken, settings_used, results_seen);
        $display("testbench: %0d flash word writes, %0d replies, %0d completed transfers",
                 writes_seen, replies_seen, dones_seen);
        if (mismatch_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
